FILE: rtl/obcc_pkg.sv
// Shared types, codes and helper functions for the one-button clock controller.
// No dependencies; every other file in rtl refers to this package by scoped names.

package obcc_pkg;

   localparam logic [3:0] BLANK_DIGIT = 4'd15;
   localparam logic [4:0] MAX_HOURS   = 5'd23;
   localparam logic [5:0] MAX_MINUTES = 6'd59;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_BOUNCE      = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHORT_LIMIT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LONG_LIMIT  = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_HOLD_CAP    = 2'd3;

   localparam logic [7:0] BOUNCE_RESET      = 8'd2;
   localparam logic [7:0] SHORT_LIMIT_RESET = 8'd20;
   localparam logic [7:0] LONG_LIMIT_RESET  = 8'd30;
   localparam logic [7:0] HOLD_CAP_RESET    = 8'd100;

   localparam logic [1:0] MODE_CLOCK   = 2'd0;
   localparam logic [1:0] MODE_HOURS   = 2'd1;
   localparam logic [1:0] MODE_MINUTES = 2'd2;

   localparam logic [1:0] PRESS_NONE  = 2'd0;
   localparam logic [1:0] PRESS_SHORT = 2'd1;
   localparam logic [1:0] PRESS_LONG  = 2'd2;

   typedef struct packed {
      logic [7:0] bounce_ticks;
      logic [7:0] short_limit_ticks;
      logic [7:0] long_limit_ticks;
      logic [7:0] hold_cap_ticks;
   } cfg_type;

   typedef struct packed {
      logic       button_down;
      logic [5:0] rtc_hours_bcd;
      logic [6:0] rtc_minutes_bcd;
   } req_type;

   typedef struct packed {
      logic [3:0] tube_0;
      logic [3:0] tube_1;
      logic [3:0] tube_2;
      logic [3:0] tube_3;
      logic       backlight_on;
      logic [1:0] in_setting;
      logic       write_time;
      logic [5:0] new_hours_bcd;
      logic [6:0] new_minutes_bcd;
   } rsp_type;

   // Packed BCD to binary, clamped at limit. Tens times ten is two shifts and an add.
   function automatic logic [6:0] bcd_to_bin(input logic [2:0] tens, input logic [3:0] units,
                                             input logic [6:0] limit);
      logic [6:0] value;
      value = {1'b0, tens, 3'b000} + {3'b000, tens, 1'b0} + {3'b000, units};
      return (value > limit) ? limit : value;
   endfunction

   // Tens digit of a value below 64, by a compare ladder.
   function automatic logic [2:0] tens_of(input logic [5:0] value);
      logic [2:0] tens;
      if (value >= 6'd60) begin
         tens = 3'd6;
      end else if (value >= 6'd50) begin
         tens = 3'd5;
      end else if (value >= 6'd40) begin
         tens = 3'd4;
      end else if (value >= 6'd30) begin
         tens = 3'd3;
      end else if (value >= 6'd20) begin
         tens = 3'd2;
      end else if (value >= 6'd10) begin
         tens = 3'd1;
      end else begin
         tens = 3'd0;
      end
      return tens;
   endfunction

   function automatic logic [3:0] units_of(input logic [5:0] value);
      logic [2:0] tens;
      logic [5:0] diff;
      tens = tens_of(value);
      diff = value - ({tens, 3'b000} >> 0) - {2'b00, tens, 1'b0};
      return diff[3:0];
   endfunction

endpackage

FILE: rtl/obcc_press_classifier.sv
// Hold counter and press classification for the one-button clock controller.
// Depends on obcc_pkg for the configuration struct and the press codes.

module obcc_press_classifier (
   input  logic             clock,
   input  logic             reset,
   input  logic             step_en,
   input  logic             button_down,
   input  obcc_pkg::cfg_type cfg,
   output logic [1:0]       press
);

   logic [7:0] hold_count_ff;
   logic [7:0] hold_count_in;
   logic [8:0] hold_inc;

   always_comb begin
      hold_inc      = {1'b0, hold_count_ff} + 9'd1;
      hold_count_in = hold_count_ff;
      press         = obcc_pkg::PRESS_NONE;
      if (button_down) begin
         hold_count_in = (hold_inc > {1'b0, cfg.hold_cap_ticks}) ? cfg.hold_cap_ticks
                                                                  : hold_inc[7:0];
      end else if (hold_count_ff != 8'd0) begin
         // Tests run in order; the first that matches decides.
         if (hold_count_ff < cfg.bounce_ticks) begin
            press = obcc_pkg::PRESS_NONE;
         end else if (hold_count_ff < cfg.short_limit_ticks) begin
            press = obcc_pkg::PRESS_SHORT;
         end else if (hold_count_ff > cfg.long_limit_ticks) begin
            press = obcc_pkg::PRESS_LONG;
         end
         hold_count_in = 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_count_ff <= 8'd0;
      end else if (step_en) begin
         hold_count_ff <= hold_count_in;
      end
   end

endmodule

FILE: rtl/obcc_mode_ctrl.sv
// Mode state machine, time editing, backlight and tube display of the controller.
// Depends on obcc_pkg for mode and press codes, the result struct and BCD helpers.

module obcc_mode_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             step_en,
   input  logic [1:0]       press,
   input  logic [5:0]       rtc_hours_bcd,
   input  logic [6:0]       rtc_minutes_bcd,
   output obcc_pkg::rsp_type result
);

   logic [1:0] mode_ff, mode_in;
   logic [4:0] edit_hours_ff, edit_hours_in;
   logic [5:0] edit_minutes_ff, edit_minutes_in;
   logic       time_changed_ff, time_changed_in;
   logic       light_ff, light_in;
   logic       write_time;
   logic [6:0] latch_hours;
   logic [6:0] latch_minutes;
   logic [2:0] write_hours_tens;

   always_comb begin
      mode_in         = mode_ff;
      edit_hours_in   = edit_hours_ff;
      edit_minutes_in = edit_minutes_ff;
      time_changed_in = time_changed_ff;
      light_in        = light_ff;
      write_time      = 1'b0;
      latch_hours     = obcc_pkg::bcd_to_bin({1'b0, rtc_hours_bcd[5:4]}, rtc_hours_bcd[3:0],
                                             {2'b00, obcc_pkg::MAX_HOURS});
      latch_minutes   = obcc_pkg::bcd_to_bin(rtc_minutes_bcd[6:4], rtc_minutes_bcd[3:0],
                                             {1'b0, obcc_pkg::MAX_MINUTES});
      case (mode_ff)
         obcc_pkg::MODE_HOURS: begin
            if (press == obcc_pkg::PRESS_SHORT) begin
               edit_hours_in   = (edit_hours_ff >= obcc_pkg::MAX_HOURS) ? 5'd0
                                                                         : edit_hours_ff + 5'd1;
               time_changed_in = 1'b1;
            end else if (press == obcc_pkg::PRESS_LONG) begin
               mode_in = obcc_pkg::MODE_MINUTES;
            end
         end
         obcc_pkg::MODE_MINUTES: begin
            if (press == obcc_pkg::PRESS_SHORT) begin
               edit_minutes_in = (edit_minutes_ff >= obcc_pkg::MAX_MINUTES) ? 6'd0
                                                                  : edit_minutes_ff + 6'd1;
               time_changed_in = 1'b1;
            end else if (press == obcc_pkg::PRESS_LONG) begin
               write_time = time_changed_ff;
               mode_in    = obcc_pkg::MODE_CLOCK;
            end
         end
         default: begin
            // The unused mode code behaves as clock mode.
            mode_in = obcc_pkg::MODE_CLOCK;
            if (press == obcc_pkg::PRESS_SHORT) begin
               light_in = ~light_ff;
            end else if (press == obcc_pkg::PRESS_LONG) begin
               edit_hours_in   = latch_hours[4:0];
               edit_minutes_in = latch_minutes[5:0];
               time_changed_in = 1'b0;
               mode_in         = obcc_pkg::MODE_HOURS;
            end
         end
      endcase
   end

   // The result reflects the state after this item's update.
   always_comb begin
      write_hours_tens       = obcc_pkg::tens_of({1'b0, edit_hours_ff});
      result.backlight_on    = light_in;
      result.in_setting      = mode_in;
      result.write_time      = write_time;
      result.new_hours_bcd   = 6'd0;
      result.new_minutes_bcd = 7'd0;
      if (write_time) begin
         result.new_hours_bcd   = {write_hours_tens[1:0],
                                   obcc_pkg::units_of({1'b0, edit_hours_ff})};
         result.new_minutes_bcd = {obcc_pkg::tens_of(edit_minutes_ff),
                                   obcc_pkg::units_of(edit_minutes_ff)};
      end
      case (mode_in)
         obcc_pkg::MODE_HOURS: begin
            result.tube_0 = {1'b0, obcc_pkg::tens_of({1'b0, edit_hours_in})};
            result.tube_1 = obcc_pkg::units_of({1'b0, edit_hours_in});
            result.tube_2 = obcc_pkg::BLANK_DIGIT;
            result.tube_3 = obcc_pkg::BLANK_DIGIT;
         end
         obcc_pkg::MODE_MINUTES: begin
            result.tube_0 = obcc_pkg::BLANK_DIGIT;
            result.tube_1 = obcc_pkg::BLANK_DIGIT;
            result.tube_2 = {1'b0, obcc_pkg::tens_of(edit_minutes_in)};
            result.tube_3 = obcc_pkg::units_of(edit_minutes_in);
         end
         default: begin
            result.tube_0 = {2'b00, rtc_hours_bcd[5:4]};
            result.tube_1 = rtc_hours_bcd[3:0];
            result.tube_2 = {1'b0, rtc_minutes_bcd[6:4]};
            result.tube_3 = rtc_minutes_bcd[3:0];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= obcc_pkg::MODE_CLOCK;
         edit_hours_ff   <= 5'd0;
         edit_minutes_ff <= 6'd0;
         time_changed_ff <= 1'b0;
         light_ff        <= 1'b0;
      end else if (step_en) begin
         mode_ff         <= mode_in;
         edit_hours_ff   <= edit_hours_in;
         edit_minutes_ff <= edit_minutes_in;
         time_changed_ff <= time_changed_in;
         light_ff        <= light_in;
      end
   end

   a_hours_range: assert property (@(posedge clock) disable iff (reset)
      edit_hours_ff <= obcc_pkg::MAX_HOURS)
      else $error("edited hours out of range");

   a_minutes_range: assert property (@(posedge clock) disable iff (reset)
      edit_minutes_ff <= obcc_pkg::MAX_MINUTES)
      else $error("edited minutes out of range");

   a_write_from_minutes: assert property (@(posedge clock) disable iff (reset)
      (step_en && write_time) |-> (mode_ff == obcc_pkg::MODE_MINUTES && time_changed_ff))
      else $error("time write outside minute setting");

   a_write_ends_setting: assert property (@(posedge clock) disable iff (reset)
      (step_en && write_time) |=> (mode_ff == obcc_pkg::MODE_CLOCK))
      else $error("time write did not return to clock mode");

   a_hold_when_idle: assert property (@(posedge clock) disable iff (reset)
      !step_en |=> ($stable(mode_ff) && $stable(light_ff)))
      else $error("mode state changed without an item");

endmodule

FILE: rtl/one_button_clock_controller.sv
// One-button clock controller: an item accepted at one edge is in the input register,
// its result enters the result register with rsp_valid high once that register is free,
// and stays there until taken. Throughput is one item per cycle unless rsp_ready stalls it;
// the update logic between the two registers is the only path and holds no loop.
// Reset (synchronous, active high) returns the thresholds to 2, 20, 30 and 100,
// clears the hold counter, selects clock mode with the backlight off, and empties
// both pipeline registers. Depends on obcc_pkg, obcc_press_classifier, obcc_mode_ctrl.

module one_button_clock_controller (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  obcc_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output obcc_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_we,
   input  logic [obcc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [obcc_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   obcc_pkg::cfg_type cfg_ff;
   obcc_pkg::req_type in_data_ff;
   obcc_pkg::rsp_type out_data_ff;
   obcc_pkg::rsp_type result;
   logic              in_valid_ff;
   logic              out_valid_ff;
   logic              out_free;
   logic              step_en;
   logic [1:0]        press;

   // The result register frees up when empty or being drained this cycle.
   assign out_free  = !out_valid_ff || rsp_ready;
   assign step_en   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bounce_ticks      <= obcc_pkg::BOUNCE_RESET;
         cfg_ff.short_limit_ticks <= obcc_pkg::SHORT_LIMIT_RESET;
         cfg_ff.long_limit_ticks  <= obcc_pkg::LONG_LIMIT_RESET;
         cfg_ff.hold_cap_ticks    <= obcc_pkg::HOLD_CAP_RESET;
      end else if (csr_we) begin
         case (csr_index)
            obcc_pkg::CSR_BOUNCE:      cfg_ff.bounce_ticks      <= csr_wdata;
            obcc_pkg::CSR_SHORT_LIMIT: cfg_ff.short_limit_ticks <= csr_wdata;
            obcc_pkg::CSR_LONG_LIMIT:  cfg_ff.long_limit_ticks  <= csr_wdata;
            obcc_pkg::CSR_HOLD_CAP:    cfg_ff.hold_cap_ticks    <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (out_free) begin
            out_valid_ff <= in_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (step_en) begin
         out_data_ff <= result;
      end
   end

   obcc_press_classifier u_classifier (
      .clock       (clock),
      .reset       (reset),
      .step_en     (step_en),
      .button_down (in_data_ff.button_down),
      .cfg         (cfg_ff),
      .press       (press)
   );

   obcc_mode_ctrl u_mode_ctrl (
      .clock           (clock),
      .reset           (reset),
      .step_en         (step_en),
      .press           (press),
      .rtc_hours_bcd   (in_data_ff.rtc_hours_bcd),
      .rtc_minutes_bcd (in_data_ff.rtc_minutes_bcd),
      .result          (result)
   );

endmodule
